// ----- src/mafidx_pkg.sv -----
package mafidx_pkg;

  localparam int OFFSET_BITS_DEF = 40;
  localparam int LEN_W = 20;
  localparam int ACC_W = 32;
  localparam int LINE_OFF_W = 40;
  localparam int TDATA_W = 128;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [LEN_W-1:0] LEN_SAT = {LEN_W{1'b1}};
  localparam logic [LEN_W-1:0] MAX_LEN_RST = LEN_W'(999999);

  // result kinds
  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_RECORD = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NOT_S = 2'd0;
  localparam logic [1:0] ERR_INVALID = 2'd1;
  localparam logic [1:0] ERR_TOO_LONG = 2'd2;

  // line modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_SKIP = 2'd1;
  localparam logic [1:0] MODE_REF = 2'd2;

  localparam logic [7:0] CH_NL = 8'h0a;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_A = 8'h61;
  localparam logic [7:0] CH_S = 8'h73;
  localparam logic [7:0] CH_PLUS = 8'h2b;

  // classified input byte, carried from front to back
  typedef struct packed {
    logic [7:0] data;
    logic       file_end;
    logic       is_nl;
    logic       is_ws;
    logic       is_digit;
    logic       is_dot;
    logic       is_a;
    logic       is_s;
  } item_t;

endpackage

// ----- src/maf_reference_line_indexer_top.sv -----
// Alignment-file reference line indexer. Feed the file one byte per transaction
// on the s_ side, with s_tlast on the last byte of each file; the next byte then
// starts a new file at offset 0. Every line that follows an 'a' line must be an
// 's' reference line; its chromosome name comes out one byte per transaction
// (m_tuser = 0), then one index record (m_tuser = 1) at the end of the line with
// start, start+size, the line's byte offset and the strand character. Errors
// (m_tuser = 2) report a bad block line, a malformed reference line or a line
// that reaches max_line_len bytes; after an error input is consumed silently
// until s_tlast. Throughput is one byte per clock while no result waits on
// m_tready. The back-end parser updates its token state and its single decimal
// multiply-accumulate once per byte, and a four-entry queue keeps input flowing
// while the output register holds a waiting result, until the queue fills.
// Via a queue slot and the output register a result reaches m_. cfg_wdata may
// only be written while no bytes are in flight.
module maf_reference_line_indexer_top #(
  parameter int OFFSET_BITS = mafidx_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // max_line_len register
  input  logic                            cfg_we,
  input  logic [mafidx_pkg::LEN_W-1:0]    cfg_wdata,
  // input bytes
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] in_byte
  input  logic                            s_tlast,   // file_end
  // results
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [7:0] name_byte, [39:8] start_pos, [72:40] end_pos, [112:73] line_offset,
  // [120:113] strand_char, [122:121] error_code, [127:123] zero
  output logic [mafidx_pkg::TDATA_W-1:0]  m_tdata,
  output logic [1:0]                      m_tuser    // [1:0] kind
);

  logic              q_valid;
  logic              q_pop;
  mafidx_pkg::item_t q_item;

  // front: classify each byte and buffer it
  mafidx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  // back: line/token parser and result register
  mafidx_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

// ----- src/mafidx_front.sv -----
module mafidx_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  output logic              q_valid,
  input  logic              q_pop,
  output mafidx_pkg::item_t q_item
);

  mafidx_pkg::item_t                 slots [mafidx_pkg::Q_DEPTH];
  logic [mafidx_pkg::Q_AW-1:0]       wr_ptr;
  logic [mafidx_pkg::Q_AW-1:0]       rd_ptr;
  logic [mafidx_pkg::Q_AW:0]         count;
  mafidx_pkg::item_t                 cls;
  logic                              push;
  logic                              pop;

  always_comb begin
    cls.data     = s_tdata;
    cls.file_end = s_tlast;
    cls.is_nl    = (s_tdata == mafidx_pkg::CH_NL);
    cls.is_ws    = s_tdata inside {mafidx_pkg::CH_SPACE, mafidx_pkg::CH_TAB};
    cls.is_digit = s_tdata inside {[mafidx_pkg::CH_ZERO:mafidx_pkg::CH_NINE]};
    cls.is_dot   = (s_tdata == mafidx_pkg::CH_DOT);
    cls.is_a     = (s_tdata == mafidx_pkg::CH_A);
    cls.is_s     = (s_tdata == mafidx_pkg::CH_S);
  end

  assign s_tready = (count != (mafidx_pkg::Q_AW+1)'(mafidx_pkg::Q_DEPTH));
  assign q_valid  = (count != '0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/mafidx_back.sv -----
module mafidx_back #(
  parameter int OFFSET_BITS = mafidx_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mafidx_pkg::LEN_W-1:0]    cfg_wdata,
  input  logic                            q_valid,
  output logic                            q_pop,
  input  mafidx_pkg::item_t               q_item,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [mafidx_pkg::TDATA_W-1:0]  m_tdata,
  output logic [1:0]                      m_tuser
);

  localparam int LW = mafidx_pkg::LEN_W;
  localparam int AW = mafidx_pkg::ACC_W;

  // parser state
  logic [OFFSET_BITS-1:0] byte_count, byte_count_next;
  logic [OFFSET_BITS-1:0] line_begin, line_begin_next;
  logic [LW-1:0]          line_length, line_length_next;
  logic                   expect_reference, expect_reference_next;
  logic [1:0]             line_mode, line_mode_next;
  logic [2:0]             token_stage, token_stage_next;
  logic                   in_token, in_token_next;
  logic                   digits_done, digits_done_next;
  logic [AW-1:0]          start_accum, start_accum_next;
  logic [AW-1:0]          size_accum, size_accum_next;
  logic [7:0]             strand_hold, strand_hold_next;
  logic                   halted, halted_next;
  logic [LW-1:0]          max_line_len;

  logic                   res_valid;
  logic [1:0]             res_kind;
  logic [mafidx_pkg::TDATA_W-1:0] res_data;

  // shared decimal accumulator: acc*10 + digit, saturating
  logic [AW-1:0]          acc_in;
  logic [AW+3:0]          acc_wide;
  logic [AW-1:0]          acc_out;

  assign acc_in   = (token_stage == 3'd2) ? start_accum : size_accum;
  assign acc_wide = {1'b0, acc_in, 3'b000} + {3'b000, acc_in, 1'b0}
                  + (AW+4)'(q_item.data[3:0]);
  assign acc_out  = (acc_wide[AW+3:AW] != '0) ? {AW{1'b1}} : acc_wide[AW-1:0];

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    logic              eol;
    logic              content;
    logic [LW-1:0]     len_now;
    logic              err;
    logic [1:0]        err_code;
    logic              name;
    logic              record;
    logic [AW:0]       end_sum;
    logic [63:0]       lb_ext;

    eol      = q_item.is_nl || q_item.file_end;
    content  = !q_item.is_nl;
    len_now  = (line_length == mafidx_pkg::LEN_SAT) ? mafidx_pkg::LEN_SAT
                                                   : line_length + 1'b1;
    err      = 1'b0;
    err_code = mafidx_pkg::ERR_NOT_S;
    name     = 1'b0;
    record   = 1'b0;
    end_sum  = '0;
    lb_ext   = 64'(line_begin);

    byte_count_next       = byte_count;
    line_begin_next       = line_begin;
    line_length_next      = line_length;
    expect_reference_next = expect_reference;
    line_mode_next        = line_mode;
    token_stage_next      = token_stage;
    in_token_next         = in_token;
    digits_done_next      = digits_done;
    start_accum_next      = start_accum;
    size_accum_next       = size_accum;
    strand_hold_next      = strand_hold;
    halted_next           = halted;

    if (!halted) begin
      if (len_now == max_line_len) begin
        err      = 1'b1;
        err_code = mafidx_pkg::ERR_TOO_LONG;
      end else begin
        if (content) begin
          case (line_mode)
            mafidx_pkg::MODE_START: begin
              if (q_item.is_a) begin
                expect_reference_next = 1'b1;
                line_mode_next        = mafidx_pkg::MODE_SKIP;
              end else if (expect_reference) begin
                expect_reference_next = 1'b0;
                if (!q_item.is_s) begin
                  err      = 1'b1;
                  err_code = mafidx_pkg::ERR_NOT_S;
                end else begin
                  line_mode_next   = mafidx_pkg::MODE_REF;
                  token_stage_next = 3'd0;
                  in_token_next    = 1'b0;
                  digits_done_next = 1'b0;
                  start_accum_next = '0;
                  size_accum_next  = '0;
                  strand_hold_next = mafidx_pkg::CH_PLUS;
                end
              end else begin
                line_mode_next = mafidx_pkg::MODE_SKIP;
              end
            end
            mafidx_pkg::MODE_REF: begin
              if (token_stage == 3'd0) begin
                // species part ends at the first dot past the line tag
                if (line_length >= LW'(2) && q_item.is_dot) begin
                  token_stage_next = 3'd1;
                  in_token_next    = 1'b0;
                end
              end else if (token_stage == 3'd7) begin
                // sequence reached, rest of line is ignored
              end else if (q_item.is_ws) begin
                if (in_token) begin
                  in_token_next    = 1'b0;
                  token_stage_next = token_stage + 1'b1;
                end
              end else if (!in_token && token_stage == 3'd6) begin
                in_token_next    = 1'b1;
                digits_done_next = 1'b0;
                token_stage_next = 3'd7;
              end else begin
                logic dd;
                dd = in_token ? digits_done : 1'b0;
                in_token_next    = 1'b1;
                digits_done_next = dd;
                if (!in_token && token_stage == 3'd4) begin
                  strand_hold_next = q_item.data;
                end
                if (token_stage == 3'd1) begin
                  name = 1'b1;
                end
                if ((token_stage == 3'd2 || token_stage == 3'd3) && !dd) begin
                  if (q_item.is_digit) begin
                    if (token_stage == 3'd2) begin
                      start_accum_next = acc_out;
                    end else begin
                      size_accum_next = acc_out;
                    end
                  end else begin
                    digits_done_next = 1'b1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
        if (!err && eol) begin
          if (line_mode_next == mafidx_pkg::MODE_START) begin
            if (expect_reference_next) begin
              expect_reference_next = 1'b0;
              err      = 1'b1;
              err_code = mafidx_pkg::ERR_NOT_S;
            end
          end else if (line_mode_next == mafidx_pkg::MODE_REF) begin
            if (token_stage_next == 3'd7) begin
              record = 1'b1;
            end else begin
              err      = 1'b1;
              err_code = mafidx_pkg::ERR_INVALID;
            end
          end
        end
      end

      if (err) begin
        halted_next = 1'b1;
      end
      byte_count_next = byte_count + 1'b1;
      if (eol) begin
        line_begin_next  = byte_count_next;
        line_length_next = '0;
        line_mode_next   = mafidx_pkg::MODE_START;
      end else begin
        line_length_next = len_now;
      end
    end else begin
      byte_count_next = byte_count + 1'b1;
    end

    // result: error beats record beats name byte
    res_valid = err || record || name;
    res_kind  = mafidx_pkg::KIND_NAME;
    res_data  = '0;
    if (err) begin
      res_kind          = mafidx_pkg::KIND_ERROR;
      res_data[122:121] = err_code;
    end else if (record) begin
      end_sum           = {1'b0, start_accum_next} + {1'b0, size_accum_next};
      res_kind          = mafidx_pkg::KIND_RECORD;
      res_data[39:8]    = start_accum_next;
      res_data[72:40]   = end_sum;
      res_data[112:73]  = lb_ext[mafidx_pkg::LINE_OFF_W-1:0];
      res_data[120:113] = strand_hold_next;
    end else if (name) begin
      res_data[7:0] = q_item.data;
    end

    // file end: the record above still sees this line's values
    if (q_item.file_end) begin
      byte_count_next       = '0;
      line_begin_next       = '0;
      line_length_next      = '0;
      expect_reference_next = 1'b0;
      line_mode_next        = mafidx_pkg::MODE_START;
      token_stage_next      = 3'd0;
      in_token_next         = 1'b0;
      digits_done_next      = 1'b0;
      start_accum_next      = '0;
      size_accum_next       = '0;
      strand_hold_next      = mafidx_pkg::CH_PLUS;
      halted_next           = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_len <= mafidx_pkg::MAX_LEN_RST;
    end else if (cfg_we) begin
      max_line_len <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      line_begin       <= '0;
      line_length      <= '0;
      expect_reference <= 1'b0;
      line_mode        <= mafidx_pkg::MODE_START;
      token_stage      <= 3'd0;
      in_token         <= 1'b0;
      digits_done      <= 1'b0;
      start_accum      <= '0;
      size_accum       <= '0;
      strand_hold      <= mafidx_pkg::CH_PLUS;
      halted           <= 1'b0;
    end else if (q_pop) begin
      byte_count       <= byte_count_next;
      line_begin       <= line_begin_next;
      line_length      <= line_length_next;
      expect_reference <= expect_reference_next;
      line_mode        <= line_mode_next;
      token_stage      <= token_stage_next;
      in_token         <= in_token_next;
      digits_done      <= digits_done_next;
      start_accum      <= start_accum_next;
      size_accum       <= size_accum_next;
      strand_hold      <= strand_hold_next;
      halted           <= halted_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (q_pop) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && res_valid) begin
      m_tdata <= res_data;
      m_tuser <= res_kind;
    end
  end

endmodule

// ----- test/tb_maf_reference_line_indexer_top.sv -----
module tb_maf_reference_line_indexer_top;
  import mafidx_pkg::*;

  // token stages of the reference line, species first
  localparam logic [2:0] TOK_SPECIES = 3'd0;
  localparam logic [2:0] TOK_CHROM   = 3'd1;
  localparam logic [2:0] TOK_START   = 3'd2;
  localparam logic [2:0] TOK_SIZE    = 3'd3;
  localparam logic [2:0] TOK_STRAND  = 3'd4;
  localparam logic [2:0] TOK_SRC     = 3'd5;
  localparam logic [2:0] TOK_SEQ     = 3'd6;
  localparam logic [2:0] TOK_DONE    = 3'd7;

  // longest correct quiet stretch is a long receiver stall or a
  // sender gap; this leaves a wide margin
  localparam int WATCHDOG_LIMIT = 2000;
  // cycles to let in-flight bytes that make no result clear the pipe
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_byte;
    logic [31:0] start_pos;
    logic [32:0] end_pos;
    logic [39:0] line_offset;
    logic [7:0]  strand_char;
    logic [1:0]  error_code;
  } maf_result_t;

  // DUT inputs, all known from time zero
  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [LEN_W-1:0]   cfg_wdata = '0;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [7:0]         s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;

  // predicted parser state
  logic [OFFSET_BITS_DEF-1:0] p_count;
  logic [OFFSET_BITS_DEF-1:0] p_line_begin;
  logic [LEN_W-1:0]           p_len;
  logic                       p_expect_ref;
  logic [1:0]                 p_mode;
  logic [2:0]                 p_stage;
  logic                       p_in_tok;
  logic                       p_digits_done;
  logic [31:0]                p_start;
  logic [31:0]                p_size;
  logic [7:0]                 p_strand;
  logic                       p_halted;
  logic [LEN_W-1:0]           p_max_len;

  maf_result_t index_results[$];   // results still owed by the DUT
  logic [7:0]  file_q[$];          // text of the file being built

  int n_fail = 0;
  int n_sent = 0;       // bytes accepted by the DUT
  int idle_cycles = 0;
  int burst_left = 0;
  int rx_left = 0;
  logic tx_bursty = 1'b1;
  logic rx_stalls = 1'b1;

  maf_reference_line_indexer_top u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // back to the start of a file; the length limit is kept
  task automatic clear_file();
    p_count = '0;
    p_line_begin = '0;
    p_len = '0;
    p_expect_ref = 1'b0;
    p_mode = MODE_START;
    p_stage = TOK_SPECIES;
    p_in_tok = 1'b0;
    p_digits_done = 1'b0;
    p_start = '0;
    p_size = '0;
    p_strand = CH_PLUS;
    p_halted = 1'b0;
  endtask

  // acc*10 + digit, saturating at 32 bits
  function automatic logic [31:0] dec_acc(input logic [31:0] acc, input logic [7:0] c);
    logic [35:0] t;
    t = {4'd0, acc} * 36'd10 + {28'd0, c - CH_ZERO};
    return (t > 36'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  // one accepted byte: advance the parser copy and queue any result
  task automatic index_byte(input logic [7:0] c, input logic fe);
    logic eol, content, ws, name, record, has_err, seq_first;
    logic [1:0] err;
    logic [LEN_W-1:0] pos, len_now;
    maf_result_t r;
    eol = (c == CH_NL) || fe;
    content = (c != CH_NL);
    ws = (c == CH_SPACE) || (c == CH_TAB);
    pos = p_len;
    len_now = (p_len == LEN_SAT) ? LEN_SAT : p_len + 1'b1;
    name = 1'b0;
    record = 1'b0;
    has_err = 1'b0;
    seq_first = 1'b0;
    err = ERR_NOT_S;
    n_sent++;
    if (p_halted) begin
      // swallowing bytes until the file ends
      if (fe) clear_file();
      else p_count = p_count + 1'b1;
    end else begin
      if (len_now == p_max_len) begin
        // too-long check wins over everything else
        has_err = 1'b1;
        err = ERR_TOO_LONG;
      end else begin
        if (content) begin
          if (p_mode == MODE_START) begin
            if (c == CH_A) begin
              p_expect_ref = 1'b1;
              p_mode = MODE_SKIP;
            end else if (p_expect_ref) begin
              p_expect_ref = 1'b0;
              if (c != CH_S) begin
                has_err = 1'b1;
                err = ERR_NOT_S;
              end else begin
                p_mode = MODE_REF;
                p_stage = TOK_SPECIES;
                p_in_tok = 1'b0;
                p_digits_done = 1'b0;
                p_start = '0;
                p_size = '0;
                p_strand = CH_PLUS;
              end
            end else begin
              p_mode = MODE_SKIP;
            end
          end else if (p_mode == MODE_REF) begin
            if (p_stage == TOK_SPECIES) begin
              // species runs up to the first dot at position 2 or later
              if (pos >= 2 && c == CH_DOT) begin
                p_stage = TOK_CHROM;
                p_in_tok = 1'b0;
              end
            end else if (p_stage != TOK_DONE) begin
              if (ws) begin
                if (p_in_tok) begin
                  p_in_tok = 1'b0;
                  p_stage = p_stage + 1'b1;
                end
              end else begin
                if (!p_in_tok) begin
                  p_in_tok = 1'b1;
                  p_digits_done = 1'b0;
                  if (p_stage == TOK_STRAND) p_strand = c;
                  if (p_stage == TOK_SEQ) begin
                    p_stage = TOK_DONE;
                    seq_first = 1'b1;
                  end
                end
                if (!seq_first) begin
                  if (p_stage == TOK_CHROM) begin
                    name = 1'b1;
                  end else if ((p_stage == TOK_START || p_stage == TOK_SIZE) &&
                               !p_digits_done) begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                      if (p_stage == TOK_START) p_start = dec_acc(p_start, c);
                      else p_size = dec_acc(p_size, c);
                    end else begin
                      p_digits_done = 1'b1;
                    end
                  end
                end
              end
            end
          end
        end
        if (!has_err && eol) begin
          if (p_mode == MODE_START) begin
            // empty line right after the block line
            if (p_expect_ref) begin
              p_expect_ref = 1'b0;
              has_err = 1'b1;
              err = ERR_NOT_S;
            end
          end else if (p_mode == MODE_REF) begin
            if (p_stage == TOK_DONE) begin
              record = 1'b1;
            end else begin
              has_err = 1'b1;
              err = ERR_INVALID;
            end
          end
        end
      end

      r = '0;
      if (has_err) begin
        r.kind = KIND_ERROR;
        r.error_code = err;
        p_halted = 1'b1;
        index_results = {index_results, r};
      end else if (record) begin
        r.kind = KIND_RECORD;
        r.start_pos = p_start;
        r.end_pos = {1'b0, p_start} + {1'b0, p_size};
        r.line_offset = p_line_begin;
        r.strand_char = p_strand;
        index_results = {index_results, r};
      end else if (name) begin
        r.kind = KIND_NAME;
        r.name_byte = c;
        index_results = {index_results, r};
      end

      p_count = p_count + 1'b1;
      if (eol) begin
        p_line_begin = p_count;
        p_len = '0;
        p_mode = MODE_START;
      end else begin
        p_len = len_now;
      end
      if (fe) clear_file();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare every m_ transaction with the oldest prediction
  // ---------------------------------------------------------------------------

  function automatic void cmp_field(input string fname, input logic [63:0] want,
                                    input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    maf_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (index_results.size() == 0) begin
        $error("result with none pending: kind %0d", m_tuser);
        n_fail++;
      end else begin
        want = index_results.pop_front();
        // m_tdata layout as given at the DUT port list
        cmp_field("kind", want.kind, m_tuser);
        cmp_field("name_byte", want.name_byte, m_tdata[7:0]);
        cmp_field("start_pos", want.start_pos, m_tdata[39:8]);
        cmp_field("end_pos", want.end_pos, m_tdata[72:40]);
        cmp_field("line_offset", want.line_offset, m_tdata[112:73]);
        cmp_field("strand_char", want.strand_char, m_tdata[120:113]);
        cmp_field("error_code", want.error_code, m_tdata[122:121]);
      end
    end
  end

  // Watchdog: any long stretch with no transaction on either side is a hang
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_maf_reference_line_indexer_top: FAIL");
      $finish;
    end
  end

  // Receiver: alternating ready and stall runs, now and then a long stall
  always @(negedge clk) begin
    if (!rx_stalls) begin
      m_tready = 1'b1;
      rx_left = 0;
    end else if (rx_left == 0) begin
      if (m_tready) begin
        m_tready = 1'b0;
        rx_left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 3);
      end else begin
        m_tready = 1'b1;
        rx_left = $urandom_range(1, 12);
      end
    end else begin
      rx_left--;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // one byte transaction; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic fe);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (tx_bursty) begin
        gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 16) : $urandom_range(1, 4);
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata = b;
    s_tlast = fe;
    do @(posedge clk); while (s_tready !== 1'b1);
    index_byte(b, fe);
    @(negedge clk);
  endtask

  // send the built file; the last byte carries tlast
  task automatic send_file();
    for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  // hold input until all owed results are out, then let the pipe empty
  task automatic drain();
    s_tvalid = 1'b0;
    s_tlast = 1'b0;
    while (index_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // only called once the DUT is idle
  task automatic write_max_len(input logic [LEN_W-1:0] v);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    p_max_len = v;
  endtask

  // ---------------------------------------------------------------------------
  // Text builders
  // ---------------------------------------------------------------------------

  // append one byte to the file being built
  task automatic put_byte(input logic [7:0] b);
    file_q = {file_q, b};
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic add_ws();
    repeat ($urandom_range(1, 3)) put_byte($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
  endtask

  // token text: lowercase only, or any byte above space (high bytes included)
  task automatic add_word(input int n, input logic letters);
    repeat (n) begin
      if (letters) put_byte(8'($urandom_range(8'h61, 8'h7a)));
      else put_byte(8'($urandom_range(8'h21, 8'hff)));
    end
  endtask

  task automatic add_number();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      6: add_text($sformatf("%0d", $urandom));
      7: repeat ($urandom_range(10, 12)) put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      8: begin
        // a sign ends the number at once
        add_text($urandom_range(0, 1) ? "-" : "+");
        add_text($sformatf("%0d", $urandom_range(0, 999)));
      end
      9: begin
        add_text($sformatf("%0d", $urandom_range(0, 99999)));
        add_word($urandom_range(1, 3), 1'b0);
      end
      10: add_text("4294967295");
      11: add_text("4294967296");
      default: add_text($sformatf("%0d", $urandom_range(0, 1000000)));
    endcase
  endtask

  // random bytes but no newline, then a newline
  task automatic add_noise_line();
    logic [7:0] b;
    repeat ($urandom_range(0, 12)) begin
      b = 8'($urandom_range(0, 255));
      put_byte((b == CH_NL) ? 8'h0b : b);
    end
    put_byte(CH_NL);
  endtask

  // 's' line; a broken one drops the dot, puts it at position 1, or cuts tokens
  task automatic add_ref_line(input logic intact);
    int fault, ntok, sr;
    fault = intact ? 0 : $urandom_range(1, 3);
    ntok = (fault == 1) ? $urandom_range(0, 4) : 6;
    add_text((fault == 3) ? "s." : "s");
    add_ws();
    add_word($urandom_range(1, 6), 1'b1);
    if (fault < 2) add_text(".");
    for (int t = 0; t < ntok; t++) begin
      if (t != 0 || $urandom_range(0, 7) == 0) add_ws();
      case (3'(t + 1))
        TOK_CHROM: begin
          if ($urandom_range(0, 9) < 7) add_text($sformatf("chr%0d", $urandom_range(1, 22)));
          else add_word($urandom_range(1, 8), 1'b0);
        end
        TOK_START, TOK_SIZE, TOK_SRC: add_number();
        TOK_STRAND: begin
          sr = $urandom_range(0, 9);
          if (sr < 5) add_text("+");
          else if (sr < 9) add_text("-");
          else add_word($urandom_range(1, 2), 1'b0);
        end
        default: add_word($urandom_range(1, 20), 1'b0);
      endcase
    end
    if ($urandom_range(0, 7) == 0) add_ws();
    put_byte(CH_NL);
  endtask

  task automatic add_block();
    int r;
    if ($urandom_range(0, 7) == 0) add_text("a\n");   // reopened block
    add_text("a");
    if ($urandom_range(0, 1)) add_text($sformatf(" score=%0d", $urandom_range(0, 99999)));
    put_byte(CH_NL);
    r = $urandom_range(0, 19);
    if (r < 15) add_ref_line(1'b1);
    else if (r < 18) add_ref_line(1'b0);
    else if (r == 18) put_byte(CH_NL);
    else add_noise_line();
    repeat ($urandom_range(0, 2)) begin
      r = $urandom_range(0, 2);
      if (r == 0) add_ref_line(1'b1);      // other species, not indexed
      else if (r == 1) add_text("i x C 0 C 0\n");
      else put_byte(CH_NL);
    end
  endtask

  // mostly well-formed files, some raw noise, and odd file endings
  task automatic build_file();
    int r, n;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 30)) put_byte(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) add_text("##maf version=1\n");
      repeat ($urandom_range(1, 3)) begin
        add_block();
        if ($urandom_range(0, 3) == 0) add_noise_line();
      end
    end
    r = $urandom_range(0, 9);
    if (r == 6 || r == 7) begin
      // tlast on a content byte instead of a newline
      if (file_q.size() > 1 && file_q[$] == CH_NL) void'(file_q.pop_back());
    end else if (r == 8 && file_q.size() > 1) begin
      // file cut mid-line, often inside an open block
      n = $urandom_range(1, file_q.size() - 1);
      while (file_q.size() > n) void'(file_q.pop_back());
    end else if (r == 9) begin
      put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // well-formed records: offsets, number extremes, signs, tabs, tlast ending
  task automatic test_records();
    add_text("##maf version=1\na score=1\ns hg.chr1 0 0 + 100 ACGT\n");
    add_text("s mm.chr2 5 6 + 9 AC\n\na\n");
    add_text("s h.chrX\t4294967295  4294967295\t- 5 A\n");
    put_byte(8'h00);
    put_byte(8'hff);
    put_byte(8'h80);
    put_byte(CH_NL);
    send_file();
    add_text("a\ns h.c 99999999999 12 + 1 A");     // saturated start, record on tlast
    send_file();
    add_text("a\na\ns h.c -5 +7 + 1 A\n");          // reopened block, signs give 0
    send_file();
    add_text("a\ns h..c 12x3 4 \t - 1 A \n");       // dot in name, digits cut by x
    send_file();
  endtask

  // each error halts the parser until tlast, so one case per file
  task automatic test_errors();
    add_text("a\nq x\ns h.c 1 2 + 3 A\n");   // block line not 's'
    send_file();
    add_text("a\n\na\n");                     // empty line after block line
    send_file();
    add_text("a\ns.c 1 2 + 3 A\n");           // dot at position 1 does not count
    send_file();
    add_text("a\ns hc 1 2 + 3 A\n");          // no dot at all
    send_file();
    add_text("a\ns h.chr1 1 2 +\n");          // tokens missing, name already out
    send_file();
    add_text("a\ns h.c 1 2 + 3");             // no sequence before tlast
    send_file();
    add_text("a");                            // open block at file end is fine
    send_file();
    add_text("x\na\ns h.c 7 8 - 9 G\n");      // new file restarts offsets at 0
    send_file();
  endtask

  // too-long check on plain lines, on the record byte, and the lowest limit
  task automatic test_line_limit();
    drain();
    write_max_len(LEN_W'(7));
    add_text("abcde\nabcdef\nzz\n");
    send_file();
    drain();
    write_max_len(LEN_W'(16));
    add_text("a\ns h.c 1 2 + 3 A\n");         // limit hits on the record byte
    send_file();
    drain();
    write_max_len(LEN_W'(2));
    add_text("\n\nx\n");
    send_file();
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] max_len, input logic bursty,
                           input logic stalls, input int n_bytes);
    int target;
    drain();
    write_max_len(max_len);
    tx_bursty = bursty;
    rx_stalls = stalls;
    target = n_sent + n_bytes;
    while (n_sent < target) begin
      build_file();
      send_file();
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  // random files under several limits, both ends busy or free
  task automatic test_random_files();
    run_phase(LEN_W'(1000000), 1'b1, 1'b1, 350);
    run_phase(LEN_W'(40), 1'b1, 1'b0, 230);
    run_phase(LEN_W'(2), 1'b1, 1'b1, 50);
    run_phase(LEN_W'(24), 1'b0, 1'b1, 180);
    run_phase(MAX_LEN_RST, 1'b0, 1'b0, 210);
    run_phase(MAX_LEN_RST, 1'b1, 1'b1, 230);
  endtask

  initial begin
    clear_file();
    p_max_len = MAX_LEN_RST;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_records();
    test_errors();
    test_line_limit();
    test_random_files();
    drain();
    if (n_fail == 0) begin
      $display("tb_maf_reference_line_indexer_top: PASS");
    end else begin
      $display("tb_maf_reference_line_indexer_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- maf_reference_line_indexer_top.f -----
src/mafidx_pkg.sv
src/mafidx_front.sv
src/mafidx_back.sv
src/maf_reference_line_indexer_top.sv
test/tb_maf_reference_line_indexer_top.sv
